[rtl/nlj_pkg.sv]
// Shared types, constants and the comparison function of the nested loop join matcher.
`default_nettype none
package nlj_pkg;

	localparam int ROWS      = 1024;
	localparam int BATCH     = 64;
	localparam int KEY_WIDTH = 32;

	localparam int ADDR_W  = $clog2(ROWS);
	localparam int CNT_W   = $clog2(ROWS + 1);
	localparam int BATCH_W = $clog2(BATCH + 1);
	localparam int ROW_W   = 2 * KEY_WIDTH + 2;
	localparam int IDX_W   = 10;

	localparam logic [1:0] REQ_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] REQ_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] REQ_RUN        = 2'd2;
	localparam logic [1:0] REQ_CLEAR      = 2'd3;

	localparam logic [2:0] OP_EQ       = 3'd0;
	localparam logic [2:0] OP_NE       = 3'd1;
	localparam logic [2:0] OP_LT       = 3'd2;
	localparam logic [2:0] OP_GT       = 3'd3;
	localparam logic [2:0] OP_LE       = 3'd4;
	localparam logic [2:0] OP_GE       = 3'd5;
	localparam logic [2:0] OP_DISTINCT = 3'd6;

	localparam logic [1:0] CFG_FIRST_OP   = 2'd0;
	localparam logic [1:0] CFG_SECOND_OP  = 2'd1;
	localparam logic [1:0] CFG_COND_COUNT = 2'd2;
	localparam logic [1:0] CFG_KEYS_SIGN  = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key_one;
		logic [31:0] key_two;
		logic        null_one;
		logic        null_two;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] left_index;
		logic [IDX_W-1:0] right_index;
		logic             pair_valid;
		logic             last;
		logic             done_res;
	} res_t;

	typedef struct packed {
		logic load_left;
		logic load_right;
		logic clear;
		logic run_init;
		logic wrap;
		logic compare;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_ok;
		logic left_end;
		logic right_end;
		logic batch_full;
	} sts_t;

	function automatic logic holds(input logic [2:0] op, input logic [KEY_WIDTH-1:0] a,
			input logic [KEY_WIDTH-1:0] b, input logic na, input logic nb, input logic sgn);
		logic [KEY_WIDTH-1:0] ax;
		logic [KEY_WIDTH-1:0] bx;
		logic                 r;
		ax = a;
		bx = b;
		if (sgn) begin
			ax[KEY_WIDTH-1] = ~a[KEY_WIDTH-1];
			bx[KEY_WIDTH-1] = ~b[KEY_WIDTH-1];
		end
		case (op)
			OP_EQ:       r = !na && !nb && (ax == bx);
			OP_NE:       r = !na && !nb && (ax != bx);
			OP_LT:       r = !na && !nb && (ax < bx);
			OP_GT:       r = !na && !nb && (ax > bx);
			OP_LE:       r = !na && !nb && (ax <= bx);
			OP_GE:       r = !na && !nb && (ax >= bx);
			OP_DISTINCT: r = (na != nb) || (!na && !nb && (a != b));
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/nlj_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module nlj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/nlj_datapath.sv]
// Datapath: row stores, counts, cursors, pair comparison and result register.
`default_nettype none
module nlj_datapath (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire nlj_pkg::req_t request,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [2:0]   cfg_wdata,
	input  wire nlj_pkg::cmd_t cmd,
	output nlj_pkg::sts_t     sts,
	output nlj_pkg::res_t     result,
	output logic              result_valid
);

	localparam int KW = nlj_pkg::KEY_WIDTH;

	logic [2:0]                 first_op_q;
	logic [2:0]                 second_op_q;
	logic [1:0]                 cond_count_q;
	logic                       keys_signed_q;
	logic [nlj_pkg::CNT_W-1:0]  left_rows_q;
	logic [nlj_pkg::CNT_W-1:0]  right_rows_q;
	logic [nlj_pkg::CNT_W-1:0]  lc_q;
	logic [nlj_pkg::CNT_W-1:0]  rc_q;
	logic [nlj_pkg::BATCH_W-1:0] count_q;
	logic [nlj_pkg::IDX_W-1:0]  pend_l_q;
	logic [nlj_pkg::IDX_W-1:0]  pend_r_q;
	logic                       pend_valid_q;
	nlj_pkg::res_t              res_q;
	logic                       res_valid_q;

	logic [nlj_pkg::ROW_W-1:0]  wrow;
	logic [nlj_pkg::ROW_W-1:0]  lrow;
	logic [nlj_pkg::ROW_W-1:0]  rrow;
	logic                       left_full;
	logic                       right_full;
	logic                       match;

	assign wrow = {request.null_two, request.null_one,
		KW'(request.key_two), KW'(request.key_one)};
	assign left_full  = (left_rows_q == nlj_pkg::CNT_W'(nlj_pkg::ROWS));
	assign right_full = (right_rows_q == nlj_pkg::CNT_W'(nlj_pkg::ROWS));

	nlj_ram #(.WIDTH(nlj_pkg::ROW_W), .DEPTH(nlj_pkg::ROWS)) u_left_ram (
		.clk   (clk),
		.we    (cmd.load_left && !left_full),
		.waddr (left_rows_q[nlj_pkg::ADDR_W-1:0]),
		.wdata (wrow),
		.raddr (lc_q[nlj_pkg::ADDR_W-1:0]),
		.rdata (lrow)
	);

	nlj_ram #(.WIDTH(nlj_pkg::ROW_W), .DEPTH(nlj_pkg::ROWS)) u_right_ram (
		.clk   (clk),
		.we    (cmd.load_right && !right_full),
		.waddr (right_rows_q[nlj_pkg::ADDR_W-1:0]),
		.wdata (wrow),
		.raddr (rc_q[nlj_pkg::ADDR_W-1:0]),
		.rdata (rrow)
	);

	assign match = nlj_pkg::holds(first_op_q, lrow[KW-1:0], rrow[KW-1:0],
			lrow[2*KW], rrow[2*KW], keys_signed_q) &&
		(!cond_count_q[1] || nlj_pkg::holds(second_op_q, lrow[2*KW-1:KW],
			rrow[2*KW-1:KW], lrow[2*KW+1], rrow[2*KW+1], keys_signed_q));

	assign sts.left_end   = (lc_q >= left_rows_q);
	assign sts.right_end  = (rc_q >= right_rows_q);
	assign sts.scan_ok    = !sts.left_end && !sts.right_end;
	assign sts.batch_full = (count_q == nlj_pkg::BATCH_W'(nlj_pkg::BATCH));

	assign result       = res_q;
	assign result_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_op_q    <= nlj_pkg::OP_EQ;
			second_op_q   <= nlj_pkg::OP_EQ;
			cond_count_q  <= 2'd1;
			keys_signed_q <= 1'b1;
			left_rows_q   <= '0;
			right_rows_q  <= '0;
			lc_q          <= '0;
			rc_q          <= '0;
			count_q       <= '0;
			pend_valid_q  <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					nlj_pkg::CFG_FIRST_OP:   first_op_q    <= cfg_wdata;
					nlj_pkg::CFG_SECOND_OP:  second_op_q   <= cfg_wdata;
					nlj_pkg::CFG_COND_COUNT: cond_count_q  <= cfg_wdata[1:0];
					nlj_pkg::CFG_KEYS_SIGN:  keys_signed_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.load_left && !left_full) begin
				left_rows_q <= left_rows_q + 1'b1;
			end
			if (cmd.load_right && !right_full) begin
				right_rows_q <= right_rows_q + 1'b1;
			end
			if (cmd.clear) begin
				left_rows_q  <= '0;
				right_rows_q <= '0;
				lc_q         <= '0;
				rc_q         <= '0;
			end
			if (cmd.run_init) begin
				count_q      <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.wrap) begin
				lc_q <= '0;
				rc_q <= rc_q + 1'b1;
			end
			if (cmd.compare) begin
				lc_q <= lc_q + 1'b1;
				if (match) begin
					count_q      <= count_q + 1'b1;
					pend_l_q     <= nlj_pkg::IDX_W'(lc_q);
					pend_r_q     <= nlj_pkg::IDX_W'(rc_q);
					pend_valid_q <= 1'b1;
					if (pend_valid_q) begin
						res_valid_q       <= 1'b1;
						res_q.left_index  <= pend_l_q;
						res_q.right_index <= pend_r_q;
						res_q.pair_valid  <= 1'b1;
						res_q.last        <= 1'b0;
						res_q.done_res    <= 1'b0;
					end
				end
			end
			if (cmd.finish) begin
				res_valid_q       <= 1'b1;
				res_q.left_index  <= pend_valid_q ? pend_l_q : '0;
				res_q.right_index <= pend_valid_q ? pend_r_q : '0;
				res_q.pair_valid  <= pend_valid_q;
				res_q.last        <= 1'b1;
				res_q.done_res    <= !sts.scan_ok;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/nlj_ctrl.sv]
// Controller state machine that sequences loads, clears and pair scans.
`default_nettype none
module nlj_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    req_type,
	input  wire nlj_pkg::sts_t sts,
	output nlj_pkg::cmd_t      cmd,
	output logic               busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_STEP,
		S_CMP,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req_type)
						nlj_pkg::REQ_LOAD_LEFT:  cmd.load_left = 1'b1;
						nlj_pkg::REQ_LOAD_RIGHT: cmd.load_right = 1'b1;
						nlj_pkg::REQ_CLEAR:      cmd.clear = 1'b1;
						default: begin
							cmd.run_init = 1'b1;
							state_d      = sts.scan_ok ? S_STEP : S_FIN;
						end
					endcase
				end
			end
			S_STEP: begin
				if (sts.right_end) begin
					state_d = S_FIN;
				end else if (sts.left_end) begin
					cmd.wrap = 1'b1;
				end else if (sts.batch_full) begin
					state_d = S_FIN;
				end else begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = S_STEP;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

[rtl/nested_loop_join_matcher_unit.sv]
// Top level of the nested loop join matcher: controller and datapath.
// A request is taken when start is high and busy is low. Loads and clears leave busy low.
// A run raises busy after its accept cycle and scans each (left, right) pair with a step
// state that reads both row memories at the cursors, followed by a compare state. Each wrap of
// the inner loop takes a step state of its own, the end of the run is detected in a step state
// and the final result is formed in a closing state. A run that finds nothing to scan goes
// straight from its accept cycle to the closing state. Results appear on result for one cycle
// each with result_valid high and cannot be held off; a match is shown when the next match is
// found or the run ends, so the final result carries last.
`default_nettype none
module nested_loop_join_matcher_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire nlj_pkg::req_t request,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [2:0]    cfg_wdata,
	output nlj_pkg::res_t      result,
	output logic               result_valid
);

	nlj_pkg::cmd_t cmd;
	nlj_pkg::sts_t sts;

	nlj_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (request.req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	nlj_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
`default_nettype wire

[dv/tb_nested_loop_join_matcher_unit.sv]
// Self-checking testbench for the nested loop join matcher with a built-in pair predictor.
`default_nettype none
module tb_nested_loop_join_matcher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	nlj_pkg::req_t request = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [2:0] cfg_wdata = '0;
	nlj_pkg::res_t result;
	logic result_valid;

	nested_loop_join_matcher_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.result(result), .result_valid(result_valid)
	);

	always #10 clk = ~clk;

	typedef struct {
		logic [31:0] k1;
		logic [31:0] k2;
		logic n1;
		logic n2;
	} row_t;

	row_t left_store[nlj_pkg::ROWS];
	row_t right_store[nlj_pkg::ROWS];
	int unsigned left_count, right_count, left_pos, right_pos;
	logic [2:0] op_one, op_two;
	logic [1:0] cond_count;
	logic sign_mode;

	nlj_pkg::req_t pending_requests[$];
	nlj_pkg::res_t expected_pairs[$];
	int mismatches = 0;
	int send_idle = 20;
	bit taken = 1'b0;

	function automatic bit key_holds(logic [2:0] op, logic [31:0] a, logic [31:0] b,
			logic na, logic nb);
		logic [31:0] ax;
		logic [31:0] bx;
		if (op == nlj_pkg::OP_DISTINCT)
			return (na != nb) || (!na && !nb && a != b);
		if (na || nb)
			return 0;
		ax = sign_mode ? (a ^ 32'h8000_0000) : a;
		bx = sign_mode ? (b ^ 32'h8000_0000) : b;
		case (op)
			nlj_pkg::OP_EQ: return ax == bx;
			nlj_pkg::OP_NE: return ax != bx;
			nlj_pkg::OP_LT: return ax < bx;
			nlj_pkg::OP_GT: return ax > bx;
			nlj_pkg::OP_LE: return ax <= bx;
			nlj_pkg::OP_GE: return ax >= bx;
			default: return 0;
		endcase
	endfunction

	function automatic bit rows_join(row_t l, row_t r);
		if (!key_holds(op_one, l.k1, r.k1, l.n1, r.n1))
			return 0;
		if (cond_count >= 2 && !key_holds(op_two, l.k2, r.k2, l.n2, r.n2))
			return 0;
		return 1;
	endfunction

	task automatic predict_request(nlj_pkg::req_t rq);
		int unsigned found;
		nlj_pkg::res_t r;
		row_t nr;
		found = 0;
		nr.k1 = rq.key_one;
		nr.k2 = rq.key_two;
		nr.n1 = rq.null_one;
		nr.n2 = rq.null_two;
		case (rq.req_type)
			nlj_pkg::REQ_LOAD_LEFT: if (left_count < nlj_pkg::ROWS) begin
				left_store[left_count] = nr;
				left_count++;
			end
			nlj_pkg::REQ_LOAD_RIGHT: if (right_count < nlj_pkg::ROWS) begin
				right_store[right_count] = nr;
				right_count++;
			end
			nlj_pkg::REQ_CLEAR: begin
				left_count = 0;
				right_count = 0;
				left_pos = 0;
				right_pos = 0;
			end
			default: begin
				if (left_pos < left_count && right_pos < right_count) begin
					while (right_pos < right_count) begin
						if (left_pos >= left_count) begin
							left_pos = 0;
							right_pos++;
							continue;
						end
						if (found >= nlj_pkg::BATCH)
							break;
						if (rows_join(left_store[left_pos], right_store[right_pos])) begin
							r.left_index = left_pos[9:0];
							r.right_index = right_pos[9:0];
							r.pair_valid = 1;
							r.last = 0;
							r.done_res = 0;
							expected_pairs.push_back(r);
							found++;
						end
						left_pos++;
					end
				end
				if (found == 0)
					expected_pairs.push_back('0);
				expected_pairs[$].last = 1;
				expected_pairs[$].done_res = !(left_pos < left_count && right_pos < right_count);
			end
		endcase
	endtask

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			predict_request(request);
			taken <= 1'b1;
		end else begin
			taken <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !taken) begin
			end else if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
				request <= pending_requests.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		nlj_pkg::res_t e;
		if (result_valid) begin
			if (expected_pairs.size() == 0) begin
				report_mismatch("result with none expected");
			end else begin
				e = expected_pairs.pop_front();
				if (result.left_index !== e.left_index)
					report_mismatch($sformatf("left_index %0d exp %0d", result.left_index,
						e.left_index));
				if (result.right_index !== e.right_index)
					report_mismatch($sformatf("right_index %0d exp %0d", result.right_index,
						e.right_index));
				if (result.pair_valid !== e.pair_valid)
					report_mismatch("pair_valid");
				if (result.last !== e.last)
					report_mismatch("last");
				if (result.done_res !== e.done_res)
					report_mismatch("done_res");
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [2:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			nlj_pkg::CFG_FIRST_OP: op_one = val;
			nlj_pkg::CFG_SECOND_OP: op_two = val;
			nlj_pkg::CFG_COND_COUNT: cond_count = val[1:0];
			default: sign_mode = val[0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_requests.size() > 0 || start || busy || expected_pairs.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic nlj_pkg::req_t make_row(logic [1:0] kind, int pool);
		nlj_pkg::req_t q;
		q.req_type = kind;
		q.key_one = (pool > 0) ? $urandom_range(pool - 1) : $urandom;
		q.key_two = (pool > 0) ? $urandom_range(pool - 1) : $urandom;
		if ($urandom_range(3) == 0) q.key_one = q.key_one ^ 32'h8000_0000;
		if ($urandom_range(3) == 0) q.key_two = ~q.key_two;
		q.null_one = ($urandom_range(9) == 0);
		q.null_two = ($urandom_range(9) == 0);
		return q;
	endfunction

	task automatic queue_request(logic [1:0] kind, logic [31:0] a, logic [31:0] b,
			logic na, logic nb);
		nlj_pkg::req_t q;
		q.req_type = kind;
		q.key_one = a;
		q.key_two = b;
		q.null_one = na;
		q.null_two = nb;
		pending_requests.push_back(q);
	endtask

	task automatic random_chunk();
		int nl, nr, runs;
		nl = $urandom_range(1, 12);
		nr = $urandom_range(1, 10);
		pending_requests.push_back(make_row(nlj_pkg::REQ_CLEAR, 4));
		repeat (nl) pending_requests.push_back(make_row(nlj_pkg::REQ_LOAD_LEFT, 4));
		repeat (nr) pending_requests.push_back(make_row(nlj_pkg::REQ_LOAD_RIGHT, 4));
		runs = $urandom_range(1, 4);
		repeat (runs) begin
			pending_requests.push_back(make_row(nlj_pkg::REQ_RUN, 0));
			if ($urandom_range(4) == 0)
				pending_requests.push_back(make_row(2'($urandom_range(1)), 0));
		end
	endtask

	initial begin
		int sent;
		int queued;
		op_one = nlj_pkg::OP_EQ;
		op_two = nlj_pkg::OP_EQ;
		cond_count = 1;
		sign_mode = 1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, nulls, empty sides, batch limit with resume.
		queue_request(nlj_pkg::REQ_RUN, 0, 0, 0, 0);
		queue_request(nlj_pkg::REQ_LOAD_LEFT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		queue_request(nlj_pkg::REQ_RUN, 0, 0, 0, 0);
		queue_request(nlj_pkg::REQ_LOAD_RIGHT, 32'hFFFF_FFFF, 0, 0, 1);
		queue_request(nlj_pkg::REQ_LOAD_RIGHT, 32'h0, 32'hFFFF_FFFF, 1, 0);
		queue_request(nlj_pkg::REQ_LOAD_LEFT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
		queue_request(nlj_pkg::REQ_LOAD_LEFT, 32'h0, 0, 0, 0);
		queue_request(nlj_pkg::REQ_RUN, 0, 0, 0, 0);
		queue_request(nlj_pkg::REQ_RUN, 0, 0, 0, 0);
		queue_request(nlj_pkg::REQ_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < 9; i++) queue_request(nlj_pkg::REQ_LOAD_LEFT, 5, 5, 0, 0);
		for (int i = 0; i < 8; i++) queue_request(nlj_pkg::REQ_LOAD_RIGHT, 5, 5, 0, 0);
		queue_request(nlj_pkg::REQ_RUN, 0, 0, 0, 0);
		queue_request(nlj_pkg::REQ_RUN, 0, 0, 0, 0);
		wait_idle();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 1) ? 71 : (ph == 0 ? 20 : 0);
			sent = 0;
			for (int c = 0; c < 9; c++) begin
				case (c)
					0: begin
						write_reg(nlj_pkg::CFG_FIRST_OP, nlj_pkg::OP_DISTINCT);
						write_reg(nlj_pkg::CFG_COND_COUNT, 3'd2);
						write_reg(nlj_pkg::CFG_SECOND_OP, 3'd7);
						write_reg(nlj_pkg::CFG_KEYS_SIGN, 3'd0);
					end
					1: begin
						write_reg(nlj_pkg::CFG_SECOND_OP, nlj_pkg::OP_DISTINCT);
						write_reg(nlj_pkg::CFG_COND_COUNT, 3'd3);
					end
					2: begin
						write_reg(nlj_pkg::CFG_COND_COUNT, 3'd0);
						write_reg(nlj_pkg::CFG_FIRST_OP, 3'd7);
					end
					default: begin
						write_reg(nlj_pkg::CFG_FIRST_OP, 3'($urandom_range(6)));
						write_reg(nlj_pkg::CFG_SECOND_OP, 3'($urandom_range(6)));
						write_reg(nlj_pkg::CFG_COND_COUNT, 3'($urandom_range(1, 2)));
						write_reg(nlj_pkg::CFG_KEYS_SIGN, 3'($urandom_range(1)));
					end
				endcase
				while (sent < 13 * (c + 1)) begin
					queued = pending_requests.size();
					random_chunk();
					sent = sent + pending_requests.size() - queued;
				end
				wait_idle();
			end
		end
		if (mismatches == 0 && expected_pairs.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

[nested_loop_join_matcher_unit.f]
rtl/nlj_pkg.sv
rtl/nlj_ram.sv
rtl/nlj_datapath.sv
rtl/nlj_ctrl.sv
rtl/nested_loop_join_matcher_unit.sv
dv/tb_nested_loop_join_matcher_unit.sv
